// ===== rtl/zrrfp_pkg.sv =====
// types, constants and header length tables for the raw/rle frame parser
`default_nettype none

package zrrfp_pkg;

  localparam logic [31:0] MagicWord     = 32'hfd2fb528;
  localparam int unsigned ReservedBit   = 3;
  localparam logic [16:0] TwoByteOffset = 17'd256;
  localparam logic [31:0] CapReset      = 32'd131072;

  // result queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // parser phases, one-hot
  typedef enum logic [7:0] {
    PhMagic  = 8'b0000_0001,
    PhDesc   = 8'b0000_0010,
    PhHdr    = 8'b0000_0100,
    PhBlkHdr = 8'b0000_1000,
    PhRaw    = 8'b0001_0000,
    PhRle    = 8'b0010_0000,
    PhChk    = 8'b0100_0000,
    PhDone   = 8'b1000_0000
  } phase_e;

  typedef enum logic [3:0] {
    StOk           = 4'd0,
    StMagic        = 4'd1,
    StReservedBit  = 4'd2,
    StTruncated    = 4'd3,
    StSizeOverCap  = 4'd4,
    StReservedBlk  = 4'd5,
    StCompressed   = 4'd6,
    StBlockOverCap = 4'd7,
    StEmptyRle     = 4'd8,
    StTrailing     = 4'd9,
    StSizeMismatch = 4'd10
  } status_e;

  // block type codes
  localparam logic [1:0] BlkRaw  = 2'd0;
  localparam logic [1:0] BlkRle  = 2'd1;
  localparam logic [1:0] BlkComp = 2'd2;
  localparam logic [1:0] BlkRsvd = 2'd3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [20:0] repeat_count;
    logic        is_status;
    status_e     status_code;
    logic [31:0] total_out;
    logic        last;
  } item_t;

  function automatic logic [3:0] dict_len(input logic [1:0] flag);
    logic [3:0] len;
    unique case (flag)
      2'd0: len = 4'd0;
      2'd1: len = 4'd1;
      2'd2: len = 4'd2;
      default: len = 4'd4;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] fcs_len(input logic [1:0] flag, input logic single_seg);
    logic [3:0] len;
    unique case (flag)
      2'd0: len = single_seg ? 4'd1 : 4'd0;
      2'd1: len = 4'd2;
      2'd2: len = 4'd4;
      default: len = 4'd8;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/zstd_raw_rle_frame_parser_top.sv =====
// zstandard frame parser for raw and rle blocks, byte stream in, items out
`default_nettype none

// Takes one frame byte per beat and updates the parser state in the same cycle, so a new
// byte is accepted every cycle while in_ready_o is high; a byte's results are put into
// the queue as it is taken. A raw block byte gives one item with repeat count 1, an rle
// block gives one item carrying its size as repeat count, and the byte with end_of_frame
// gives a status item with last set, after any data item of that same byte. Results wait
// in a four-entry queue; in_ready_o drops only while fewer than two entries are free,
// which happens only when the consumer stalls. After an error the frame's remaining bytes
// are taken and dropped until the end mark. The output byte limit resets to 131072; the
// user must write it via cfg_we_i/cfg_wdata_i only while the block is idle (unenforced).
module zstd_raw_rle_frame_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  // frame bytes
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        end_of_frame_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       data_byte_o,
  output logic [20:0]      repeat_count_o,
  output logic             is_status_o,
  output logic [3:0]       status_code_o,
  output logic [31:0]      total_out_o,
  output logic             last_o
);

  // parser state
  logic [31:0]       cap_q;
  zrrfp_pkg::phase_e phase_q, phase_d;
  logic [3:0]        fc_q, fc_d;
  logic [31:0]       magic_q, magic_d;
  logic [7:0]        desc_q, desc_d;
  logic [63:0]       size_q, size_d;
  logic [63:0]       csize_q, csize_d;
  logic [23:0]       bhdr_q, bhdr_d;
  logic [20:0]       left_q, left_d;
  logic [1:0]        kind_q, kind_d;
  logic              lastblk_q, lastblk_d;
  logic [31:0]       opos_q, opos_d;
  zrrfp_pkg::status_e err_q, err_d;

  logic in_fire;
  logic emit_data;
  logic emit_status;
  zrrfp_pkg::item_t data_item, status_item;

  // header helpers
  logic [3:0]  pre_len, fl_len, fc_inc;
  logic [2:0]  hdr_off;
  logic [5:0]  lane_sh;
  logic [20:0] blk_size;
  logic [31:0] cap_room;
  logic [16:0] two_byte_size;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    phase_d   = phase_q;
    fc_d      = fc_q;
    magic_d   = magic_q;
    desc_d    = desc_q;
    size_d    = size_q;
    csize_d   = csize_q;
    bhdr_d    = bhdr_q;
    left_d    = left_q;
    kind_d    = kind_q;
    lastblk_d = lastblk_q;
    opos_d    = opos_q;
    err_d     = err_q;
    emit_data = 1'b0;
    data_item = '0;
    status_item = '0;

    pre_len  = {3'd0, ~desc_q[5]} + zrrfp_pkg::dict_len(desc_q[1:0]);
    fl_len   = zrrfp_pkg::fcs_len(desc_q[7:6], desc_q[5]);
    fc_inc   = fc_q + 4'd1;
    hdr_off  = fc_q[2:0] - pre_len[2:0];
    lane_sh  = {hdr_off, 3'd0};
    cap_room = cap_q - opos_q;
    blk_size = '0;
    two_byte_size = '0;

    if (err_q == zrrfp_pkg::StOk) begin
      unique case (phase_q)
        zrrfp_pkg::PhMagic: begin
          magic_d = {frame_byte_i, magic_q[31:8]};
          fc_d    = fc_inc;
          if (fc_inc == 4'd4) begin
            fc_d = 4'd0;
            if (magic_d != zrrfp_pkg::MagicWord) err_d = zrrfp_pkg::StMagic;
            else phase_d = zrrfp_pkg::PhDesc;
          end
        end
        zrrfp_pkg::PhDesc: begin
          desc_d = frame_byte_i;
          if (frame_byte_i[zrrfp_pkg::ReservedBit]) begin
            err_d = zrrfp_pkg::StReservedBit;
          end else begin
            phase_d = zrrfp_pkg::PhHdr;
            fc_d    = 4'd0;
            size_d  = '0;
          end
        end
        zrrfp_pkg::PhHdr: begin
          if (fc_q >= pre_len) size_d = size_q | ({56'd0, frame_byte_i} << lane_sh);
          fc_d = fc_inc;
          if (fc_inc >= pre_len + fl_len) begin
            two_byte_size = {1'b0, size_d[15:0]} + zrrfp_pkg::TwoByteOffset;
            csize_d = (fl_len == 4'd2) ? {47'd0, two_byte_size} : size_d;
            if (csize_d > {32'd0, cap_q}) begin
              err_d = zrrfp_pkg::StSizeOverCap;
            end else begin
              phase_d = zrrfp_pkg::PhBlkHdr;
              fc_d    = 4'd0;
              bhdr_d  = '0;
            end
          end
        end
        zrrfp_pkg::PhBlkHdr: begin
          bhdr_d = bhdr_q | ({16'd0, frame_byte_i} << {fc_q[1:0], 3'd0});
          fc_d   = fc_inc;
          if (fc_inc >= 4'd3) begin
            blk_size  = bhdr_d[23:3];
            fc_d      = 4'd0;
            lastblk_d = bhdr_d[0];
            kind_d    = bhdr_d[2:1];
            if (kind_d == zrrfp_pkg::BlkRsvd) begin
              err_d = zrrfp_pkg::StReservedBlk;
            end else if (opos_q > cap_q || {11'd0, blk_size} > cap_room) begin
              err_d = zrrfp_pkg::StBlockOverCap;
            end else if (kind_d == zrrfp_pkg::BlkComp) begin
              err_d = zrrfp_pkg::StCompressed;
            end else if (kind_d == zrrfp_pkg::BlkRle && blk_size == '0) begin
              err_d = zrrfp_pkg::StEmptyRle;
            end else begin
              left_d = blk_size;
              if (kind_d == zrrfp_pkg::BlkRle) begin
                phase_d = zrrfp_pkg::PhRle;
              end else if (blk_size == '0) begin
                // empty raw block finishes at once
                bhdr_d  = '0;
                phase_d = lastblk_d ? (desc_q[2] ? zrrfp_pkg::PhChk : zrrfp_pkg::PhDone)
                                    : zrrfp_pkg::PhBlkHdr;
              end else begin
                phase_d = zrrfp_pkg::PhRaw;
              end
            end
          end
        end
        zrrfp_pkg::PhRaw: begin
          emit_data = 1'b1;
          data_item.data_byte    = frame_byte_i;
          data_item.repeat_count = 21'd1;
          opos_d = opos_q + 32'd1;
          left_d = left_q - 21'd1;
          if (left_d == '0) begin
            fc_d    = 4'd0;
            bhdr_d  = '0;
            phase_d = lastblk_q ? (desc_q[2] ? zrrfp_pkg::PhChk : zrrfp_pkg::PhDone)
                                : zrrfp_pkg::PhBlkHdr;
          end
        end
        zrrfp_pkg::PhRle: begin
          emit_data = 1'b1;
          data_item.data_byte    = frame_byte_i;
          data_item.repeat_count = left_q;
          opos_d  = opos_q + {11'd0, left_q};
          left_d  = '0;
          fc_d    = 4'd0;
          bhdr_d  = '0;
          phase_d = lastblk_q ? (desc_q[2] ? zrrfp_pkg::PhChk : zrrfp_pkg::PhDone)
                              : zrrfp_pkg::PhBlkHdr;
        end
        zrrfp_pkg::PhChk: begin
          // checksum bytes are skipped
          fc_d = fc_inc;
          if (fc_inc >= 4'd4) begin
            fc_d    = 4'd0;
            phase_d = zrrfp_pkg::PhDone;
          end
        end
        default: begin
          // byte after a complete frame
          err_d = zrrfp_pkg::StTrailing;
        end
      endcase
    end

    emit_status = end_of_frame_i;
    if (end_of_frame_i) begin
      if (err_d == zrrfp_pkg::StOk) begin
        if (phase_d != zrrfp_pkg::PhDone) begin
          err_d = zrrfp_pkg::StTruncated;
        end else if (csize_d != '0 && csize_d != {32'd0, opos_d}) begin
          err_d = zrrfp_pkg::StSizeMismatch;
        end
      end
      status_item.is_status   = 1'b1;
      status_item.status_code = err_d;
      status_item.total_out   = opos_d;
      status_item.last        = 1'b1;
      // back to the start of a frame
      phase_d   = zrrfp_pkg::PhMagic;
      fc_d      = '0;
      magic_d   = '0;
      desc_d    = '0;
      size_d    = '0;
      csize_d   = '0;
      bhdr_d    = '0;
      left_d    = '0;
      kind_d    = '0;
      lastblk_d = 1'b0;
      opos_d    = '0;
      err_d     = zrrfp_pkg::StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= zrrfp_pkg::CapReset;
      phase_q   <= zrrfp_pkg::PhMagic;
      fc_q      <= '0;
      magic_q   <= '0;
      desc_q    <= '0;
      size_q    <= '0;
      csize_q   <= '0;
      bhdr_q    <= '0;
      left_q    <= '0;
      kind_q    <= '0;
      lastblk_q <= 1'b0;
      opos_q    <= '0;
      err_q     <= zrrfp_pkg::StOk;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (in_fire) begin
        phase_q   <= phase_d;
        fc_q      <= fc_d;
        magic_q   <= magic_d;
        desc_q    <= desc_d;
        size_q    <= size_d;
        csize_q   <= csize_d;
        bhdr_q    <= bhdr_d;
        left_q    <= left_d;
        kind_q    <= kind_d;
        lastblk_q <= lastblk_d;
        opos_q    <= opos_d;
        err_q     <= err_d;
      end
    end
  end

  // result queue: up to two pushes per beat, one pop
  zrrfp_pkg::item_t q_mem [zrrfp_pkg::QDepth];
  logic [zrrfp_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nxt;
  logic [zrrfp_pkg::QCntW-1:0] cnt_q;
  logic push_a, push_b, pop;
  zrrfp_pkg::item_t item_a;
  zrrfp_pkg::item_t head;

  assign push_a = in_fire && (emit_data || emit_status);
  assign push_b = in_fire && emit_data && emit_status;
  assign item_a = emit_data ? data_item : status_item;
  assign wr_ptr_nxt = wr_ptr_q + {{(zrrfp_pkg::QPtrW-1){1'b0}}, 1'b1};
  assign pop = out_valid_o && out_ready_i;

  // room for two results regardless of the consumer
  assign in_ready_o  = cnt_q <= zrrfp_pkg::QCntW'(zrrfp_pkg::QDepth - 2);
  assign out_valid_o = cnt_q != '0;

  always_ff @(posedge clk_i) begin
    if (push_a) q_mem[wr_ptr_q] <= item_a;
    if (push_b) q_mem[wr_ptr_nxt] <= status_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + zrrfp_pkg::QPtrW'({push_a, 1'b0} >> !push_b);
      if (pop) rd_ptr_q <= rd_ptr_q + {{(zrrfp_pkg::QPtrW-1){1'b0}}, 1'b1};
      cnt_q <= cnt_q + zrrfp_pkg::QCntW'(push_a) + zrrfp_pkg::QCntW'(push_b)
               - zrrfp_pkg::QCntW'(pop);
    end
  end

  assign head           = q_mem[rd_ptr_q];
  assign data_byte_o    = head.data_byte;
  assign repeat_count_o = head.repeat_count;
  assign is_status_o    = head.is_status;
  assign status_code_o  = head.status_code;
  assign total_out_o    = head.total_out;
  assign last_o         = head.last;

endmodule

`default_nettype wire
